FILE: hw/rtl/ecfr_pkg.sv
// Shared types, byte codes and CRC step function for the escaped CRC frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package ecfr_pkg;

    // Line byte codes
    localparam logic [7:0] FRAME_END_BYTE = 8'h0D;
    localparam logic [7:0] IDLE_BYTE      = 8'hFF;
    localparam logic [7:0] SKIP_BYTE      = 8'h40;
    localparam logic [7:0] ESCAPE_BYTE    = 8'h1B;
    localparam logic [7:0] ESCAPE_INVERT  = 8'hFF;

    // CRC-16 polynomial
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Default depth of the result queue
    localparam int OUT_FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CRC_ERROR = 2'd1,
        STATUS_EMPTY     = 2'd2
    } frame_status_t;

    // One result item
    typedef struct packed {
        logic [7:0]    data_byte;
        logic          frame_end;
        frame_status_t frame_status;
    } result_t;

    // Decoder outputs for one line byte
    typedef struct packed {
        logic        res0_valid;
        logic        res1_valid;
        result_t     res0;
        result_t     res1;
        logic [15:0] crc_next;
        logic        esc_next;
        logic        has_data_next;
    } dec_out_t;

    // Shift one byte MSB first into the register, bit entering at the LSB
    function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc_in,
                                                   input logic [7:0]  data);
        logic [15:0] r;
        logic        carry;
        r = crc_in;
        for (int i = 7; i >= 0; i--) begin
            carry = r[15];
            r = {r[14:0], data[i]};
            if (carry) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/escaped_crc_frame_receiver_core.sv
// Top level of the escaped CRC frame receiver.
`timescale 1ns / 1ps
`default_nettype none

// Receives a byte-stuffed line stream one byte per request and returns destuffed
// payload bytes followed by an end marker carrying ok, crc_error or empty status.
// A byte is taken into an input register, decoded and CRC-checked there, and
// its results go into a small result queue, so one byte is accepted every cycle
// while the output side keeps up; a request passes the input register and then
// the queue. An end byte arriving during an escape yields two results
// from one request; the queue depth (DEPTH, at least 4) absorbs that. No frame
// timeout is built in: the user must reset the block to drop a stalled frame.
module escaped_crc_frame_receiver_core
    import ecfr_pkg::*;
#(
    parameter int DEPTH = OUT_FIFO_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_data_byte,
    output logic            m_frame_end,
    output logic [1:0]      m_frame_status
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] crc_reg;
    logic        esc_reg;
    logic        has_data_reg;
    logic        room_two;
    logic        consume;
    dec_out_t    dec;
    result_t     head;

    assign consume = in_valid_reg && room_two;
    assign s_ready = !in_valid_reg || consume;

    // Hold the incoming request until the decoder can use it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    ecfr_decode u_decode (
        .rx_byte      (in_byte_reg),
        .crc_cur      (crc_reg),
        .esc_cur      (esc_reg),
        .has_data_cur (has_data_reg),
        .dec          (dec)
    );

    // Advance frame state when a byte is decoded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= 16'h0000;
            esc_reg      <= 1'b0;
            has_data_reg <= 1'b0;
        end else if (consume) begin
            crc_reg      <= dec.crc_next;
            esc_reg      <= dec.esc_next;
            has_data_reg <= dec.has_data_next;
        end
    end

    ecfr_out_fifo #(
        .DEPTH (DEPTH)
    ) u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push0      (consume && dec.res0_valid),
        .push1      (consume && dec.res1_valid),
        .wdata0     (dec.res0),
        .wdata1     (dec.res1),
        .room_two   (room_two),
        .head_valid (m_valid),
        .head       (head),
        .pop_ready  (m_ready)
    );

    assign m_data_byte    = head.data_byte;
    assign m_frame_end    = head.frame_end;
    assign m_frame_status = head.frame_status;

endmodule

`default_nettype wire

FILE: hw/rtl/ecfr_decode.sv
// Byte decoder: destuffing, CRC update and frame-end status for one line byte.
`timescale 1ns / 1ps
`default_nettype none

module ecfr_decode
    import ecfr_pkg::*;
(
    input  wire logic [7:0]  rx_byte,
    input  wire logic [15:0] crc_cur,
    input  wire logic        esc_cur,
    input  wire logic        has_data_cur,
    output dec_out_t         dec
);

    logic [15:0] crc_after;
    logic [7:0]  inv_byte;

    assign inv_byte  = rx_byte ^ ESCAPE_INVERT;
    assign crc_after = crc_shift_byte(crc_cur, esc_cur ? inv_byte : rx_byte);

    // Classify the byte and build up to two requests
    always_comb begin
        dec.res0_valid    = 1'b0;
        dec.res1_valid    = 1'b0;
        dec.res0          = '{data_byte: 8'h00, frame_end: 1'b0, frame_status: STATUS_OK};
        dec.res1          = '{data_byte: 8'h00, frame_end: 1'b0, frame_status: STATUS_OK};
        dec.crc_next      = crc_cur;
        dec.esc_next      = esc_cur;
        dec.has_data_next = has_data_cur;

        if (rx_byte inside {IDLE_BYTE, SKIP_BYTE}) begin
            // drop filler bytes, state unchanged
        end else if (rx_byte == FRAME_END_BYTE) begin
            dec.res0_valid = 1'b1;
            dec.res0.frame_end = 1'b1;
            if (esc_cur) begin
                // pending escape flushes an inverted end byte as data first
                dec.res0.data_byte    = inv_byte;
                dec.res0.frame_end    = 1'b0;
                dec.res1_valid        = 1'b1;
                dec.res1.frame_end    = 1'b1;
                dec.res1.frame_status = (crc_after != 16'h0000) ? STATUS_CRC_ERROR
                                                                : STATUS_OK;
            end else if (!has_data_cur) begin
                dec.res0.frame_status = STATUS_EMPTY;
            end else if (crc_cur != 16'h0000) begin
                dec.res0.frame_status = STATUS_CRC_ERROR;
            end else begin
                dec.res0.frame_status = STATUS_OK;
            end
            dec.crc_next      = 16'h0000;
            dec.esc_next      = 1'b0;
            dec.has_data_next = 1'b0;
        end else if (esc_cur) begin
            dec.res0_valid          = 1'b1;
            dec.res0.data_byte      = inv_byte;
            dec.crc_next            = crc_after;
            dec.esc_next            = 1'b0;
            dec.has_data_next       = 1'b1;
        end else if (rx_byte == ESCAPE_BYTE) begin
            dec.esc_next = 1'b1;
        end else begin
            dec.res0_valid          = 1'b1;
            dec.res0.data_byte      = rx_byte;
            dec.crc_next            = crc_after;
            dec.has_data_next       = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ecfr_out_fifo.sv
// Result queue: takes up to two requests per cycle, presents one at its head.
`timescale 1ns / 1ps
`default_nettype none

module ecfr_out_fifo
    import ecfr_pkg::*;
#(
    parameter int DEPTH = OUT_FIFO_DEPTH
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push0,
    input  wire logic    push1,
    input  wire result_t wdata0,
    input  wire result_t wdata1,
    output logic         room_two,
    output logic         head_valid,
    output result_t      head,
    input  wire logic    pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr1;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_ptr1    = ptr_inc(wr_ptr_reg);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    assign room_two   = (count_reg <= CNT_W'(DEPTH - 2));

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push1 ? ptr_inc(wr_ptr1) : (push0 ? wr_ptr1 : wr_ptr_reg);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store requests; payload needs no reset
    always_ff @(posedge aclk) begin
        if (push0) begin
            mem_reg[wr_ptr_reg] <= wdata0;
        end
        if (push1) begin
            mem_reg[wr_ptr1] <= wdata1;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ecfr_checker.sv
// Port-level checker for the escaped CRC frame receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ecfr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_data_byte,
    input wire logic       m_frame_end,
    input wire logic [1:0] m_frame_status
);

    // Result channel is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_byte)
                                && $stable(m_frame_end) && $stable(m_frame_status))
        else $error("stalled result changed");

    // Payload bytes carry no status
    a_payload_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_end |-> m_frame_status == 2'd0)
        else $error("status on payload byte");

    // End markers carry a zero data byte and a defined status
    a_end_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_data_byte == 8'h00 && m_frame_status != 2'd3)
        else $error("malformed end marker");

endmodule

bind escaped_crc_frame_receiver_core ecfr_checker u_ecfr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_data_byte    (m_data_byte),
    .m_frame_end    (m_frame_end),
    .m_frame_status (m_frame_status)
);

`default_nettype wire
